// File: sv/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
// Holds the outcode bit assignments, register indexes and bus sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    // Four-bit region code of one endpoint relative to the window.
    typedef logic [3:0] t_outcode;

    localparam t_outcode CODE_NONE  = 4'b0000;
    localparam t_outcode CODE_LEFT  = 4'b0001;
    localparam t_outcode CODE_RIGHT = 4'b0010;
    localparam t_outcode CODE_BELOW = 4'b0100;
    localparam t_outcode CODE_ABOVE = 4'b1000;

    // Slide counter.
    localparam int PASS_BITS = 3;
    typedef logic [PASS_BITS-1:0] t_pass;
    localparam t_pass MAX_SLIDES = 3'd4;

    // Configuration bus.
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_X_MIN = 2'd0;
    localparam t_reg_idx REG_X_MAX = 2'd1;
    localparam t_reg_idx REG_Y_MIN = 2'd2;
    localparam t_reg_idx REG_Y_MAX = 2'd3;

endpackage

`default_nettype wire

// File: sv/line_segment_clipper_top.sv
// Top level of the Cohen-Sutherland line segment clipper.
// Depends on lsc_pkg and the shared interpolation unit lsc_interp.
`timescale 1ns / 1ps
`default_nettype none

// The block clips one segment at a time against the window held in four signed
// registers (left, right, bottom, top), written over the APB port at byte addresses
// 0, 4, 8 and 12. After an input transfer it forms the outcodes of both endpoints;
// when both are zero the segment is visible, when they share a bit it is rejected,
// and otherwise the outside endpoint (the start point when both are outside) slides
// onto one window edge, tested in the order top, bottom, right, left, for at most
// four slides. A segment still undecided after four slides is reported as rejected,
// and a rejected segment returns zero coordinates. Every slide runs on a single
// interpolation unit: one multiply and then a restoring division that retires one
// quotient bit per cycle. The input side stalls while an item is in work; the
// result sits in an output register, so the next input transfer can be taken while
// it still waits for its output transfer.
module line_segment_clipper_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [COORD_BITS-1:0]        i_start_x,
    input  wire logic signed [COORD_BITS-1:0]        i_start_y,
    input  wire logic signed [COORD_BITS-1:0]        i_end_x,
    input  wire logic signed [COORD_BITS-1:0]        i_end_y,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_visible,
    output logic signed [COORD_BITS-1:0]             o_clipped_start_x,
    output logic signed [COORD_BITS-1:0]             o_clipped_start_y,
    output logic signed [COORD_BITS-1:0]             o_clipped_end_x,
    output logic signed [COORD_BITS-1:0]             o_clipped_end_y,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lsc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [lsc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lsc_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready
);

    import lsc_pkg::*;

    localparam int N = COORD_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    // Window registers.
    logic signed [N-1:0] r_win_x_min, r_win_x_max, r_win_y_min, r_win_y_max;

    // Working endpoints and sequencer.
    logic [1:0]          r_state;
    logic signed [N-1:0] r_x1, r_y1, r_x2, r_y2;
    t_pass               r_pass;
    logic                r_first;
    logic                r_horiz;
    logic signed [N-1:0] r_edge;

    // Output register.
    logic                r_out_valid;
    logic                r_vis;
    logic signed [N-1:0] r_out_x1, r_out_y1, r_out_x2, r_out_y2;

    // Combinational decisions of the check state.
    t_outcode            c1, c2, csel;
    logic                is_vis, is_rej, finish, out_free, unit_start, cfg_wr, load_out;
    logic                horiz;
    logic signed [N-1:0] edge_val, base;
    logic signed [N:0]   dx, dy, dv, dn, den;
    logic signed [N-1:0] cross_val;
    logic                unit_done;
    logic signed [N-1:0] unit_result;
    t_reg_idx            reg_idx;

    function automatic t_outcode f_outcode(
        input logic signed [N-1:0] x,
        input logic signed [N-1:0] y,
        input logic signed [N-1:0] x_min,
        input logic signed [N-1:0] x_max,
        input logic signed [N-1:0] y_min,
        input logic signed [N-1:0] y_max
    );
        t_outcode code;
        code = CODE_NONE;
        if (x < x_min) begin
            code = code | CODE_LEFT;
        end else if (x > x_max) begin
            code = code | CODE_RIGHT;
        end
        if (y < y_min) begin
            code = code | CODE_BELOW;
        end else if (y > y_max) begin
            code = code | CODE_ABOVE;
        end
        return code;
    endfunction

    always_comb begin
        c1   = f_outcode(r_x1, r_y1, r_win_x_min, r_win_x_max, r_win_y_min, r_win_y_max);
        c2   = f_outcode(r_x2, r_y2, r_win_x_min, r_win_x_max, r_win_y_min, r_win_y_max);
        csel = (c1 != CODE_NONE) ? c1 : c2;

        is_vis = ((c1 | c2) == CODE_NONE);
        is_rej = !is_vis && (((c1 & c2) != CODE_NONE) || (r_pass == MAX_SLIDES));
        finish = is_vis || is_rej;

        // Pick the edge: top first, then bottom, right and left.
        horiz = ((csel & (CODE_ABOVE | CODE_BELOW)) != CODE_NONE);
        if ((csel & CODE_ABOVE) != CODE_NONE) begin
            edge_val = r_win_y_max;
        end else if ((csel & CODE_BELOW) != CODE_NONE) begin
            edge_val = r_win_y_min;
        end else if ((csel & CODE_RIGHT) != CODE_NONE) begin
            edge_val = r_win_x_max;
        end else begin
            edge_val = r_win_x_min;
        end

        // Interpolation always runs from the current start point.
        dx        = {r_x2[N-1], r_x2} - {r_x1[N-1], r_x1};
        dy        = {r_y2[N-1], r_y2} - {r_y1[N-1], r_y1};
        cross_val = horiz ? r_y1 : r_x1;
        dn        = {edge_val[N-1], edge_val} - {cross_val[N-1], cross_val};
        base      = horiz ? r_x1 : r_y1;
        dv        = horiz ? dx : dy;
        den       = horiz ? dy : dx;

        out_free   = !r_out_valid || !i_out_stall;
        unit_start = (r_state == ST_CHECK) && !finish;
        load_out   = (r_state == ST_CHECK) && finish && out_free;
    end

    lsc_interp #(
        .COORD_BITS (COORD_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (unit_start),
        .i_base   (base),
        .i_dv     (dv),
        .i_dn     (dn),
        .i_den    (den),
        .o_done   (unit_done),
        .o_result (unit_result)
    );

    // Sequencer: idle, check outcodes, wait for the interpolation unit.
    // A new result may be loaded in the same cycle as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (!finish) begin
                        r_state <= ST_WAIT;
                    end else if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        r_state <= ST_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Endpoint and output datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_x1   <= i_start_x;
                    r_y1   <= i_start_y;
                    r_x2   <= i_end_x;
                    r_y2   <= i_end_y;
                    r_pass <= '0;
                end
            end
            ST_CHECK: begin
                if (!finish) begin
                    r_first <= (c1 != CODE_NONE);
                    r_horiz <= horiz;
                    r_edge  <= edge_val;
                end else if (out_free) begin
                    r_vis    <= is_vis;
                    r_out_x1 <= is_vis ? r_x1 : '0;
                    r_out_y1 <= is_vis ? r_y1 : '0;
                    r_out_x2 <= is_vis ? r_x2 : '0;
                    r_out_y2 <= is_vis ? r_y2 : '0;
                end
            end
            ST_WAIT: begin
                if (unit_done) begin
                    r_pass <= r_pass + 1'b1;
                    if (r_first) begin
                        r_x1 <= r_horiz ? unit_result : r_edge;
                        r_y1 <= r_horiz ? r_edge : unit_result;
                    end else begin
                        r_x2 <= r_horiz ? unit_result : r_edge;
                        r_y2 <= r_horiz ? r_edge : unit_result;
                    end
                end
            end
            default: begin
                r_pass <= '0;
            end
        endcase
    end

    // Configuration registers. The word index comes from paddr[3:2].
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x_min <= N'(0);
            r_win_x_max <= N'(1023);
            r_win_y_min <= N'(0);
            r_win_y_max <= N'(767);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_X_MIN: r_win_x_min <= pwdata[N-1:0];
                REG_X_MAX: r_win_x_max <= pwdata[N-1:0];
                REG_Y_MIN: r_win_y_min <= pwdata[N-1:0];
                REG_Y_MAX: r_win_y_max <= pwdata[N-1:0];
                default: r_win_x_min <= r_win_x_min;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_MIN: prdata = APB_DATA_BITS'(r_win_x_min);
            REG_X_MAX: prdata = APB_DATA_BITS'(r_win_x_max);
            REG_Y_MIN: prdata = APB_DATA_BITS'(r_win_y_min);
            REG_Y_MAX: prdata = APB_DATA_BITS'(r_win_y_max);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // The input side also stalls while reset is held, so no transfer is lost then.
    assign o_in_stall        = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid       = r_out_valid;
    assign o_visible         = r_vis;
    assign o_clipped_start_x = r_out_x1;
    assign o_clipped_start_y = r_out_y1;
    assign o_clipped_end_x   = r_out_x2;
    assign o_clipped_end_y   = r_out_y2;

endmodule

`default_nettype wire

// File: sv/lsc_interp.sv
// Shared interpolation unit: base + round(dv * dn / den), saturated to the coordinate range.
// One multiply, then a restoring division one quotient bit per cycle. No package needed.
`timescale 1ns / 1ps
`default_nettype none

module lsc_interp #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [COORD_BITS-1:0] i_base,
    input  wire logic signed [COORD_BITS:0]   i_dv,
    input  wire logic signed [COORD_BITS:0]   i_dn,
    input  wire logic signed [COORD_BITS:0]   i_den,
    output logic                              o_done,
    output logic signed [COORD_BITS-1:0]      o_result
);

    localparam int N  = COORD_BITS;
    localparam int W  = 2 * N + 2;          // numerator and quotient width
    localparam int R  = N + 3;              // partial remainder width
    localparam int CW = $clog2(W + 1);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MUL  = 3'd1;
    localparam logic [2:0] U_NUM  = 3'd2;
    localparam logic [2:0] U_DIV  = 3'd3;
    localparam logic [2:0] U_FIX  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [N:0]          r_a, r_b, r_c;
    logic                r_neg, r_zero;
    logic signed [N-1:0] r_base;
    logic [W-1:0]        r_num;
    logic [R-1:0]        r_rem;
    logic [CW-1:0]       r_cnt;
    logic                r_done;
    logic signed [N-1:0] r_result;

    logic [N:0]          mag_dv, mag_dn, mag_den;
    logic [N:0]          add_term;
    logic [R-1:0]        rem_sh, div_d;
    logic                ge;
    logic [N+1:0]        q_sat;
    logic signed [N+2:0] base_ext, q_ext, sum;
    logic signed [N-1:0] clamped;

    always_comb begin
        mag_dv  = i_dv[N]  ? (~i_dv + 1'b1)  : i_dv;
        mag_dn  = i_dn[N]  ? (~i_dn + 1'b1)  : i_dn;
        mag_den = i_den[N] ? (~i_den + 1'b1) : i_den;
        // Rounding offset: ties go toward plus infinity, so one less is added for negative quotients.
        add_term = r_neg ? (r_c - 1'b1) : r_c;

        rem_sh = {r_rem[R-2:0], r_num[W-1]};
        div_d  = R'({r_c, 1'b0});
        ge     = (rem_sh >= div_d);

        // Any quotient past twice the range saturates the final sum anyway.
        if (|r_num[W-1:N+1]) begin
            q_sat = {1'b1, {(N+1){1'b0}}};
        end else begin
            q_sat = {1'b0, r_num[N:0]};
        end
        base_ext = {{3{r_base[N-1]}}, r_base};
        q_ext    = {1'b0, q_sat};
        sum      = r_neg ? (base_ext - q_ext) : (base_ext + q_ext);
        if ((&sum[N+2:N-1]) || !(|sum[N+2:N-1])) begin
            clamped = sum[N-1:0];
        end else if (sum[N+2]) begin
            clamped = {1'b1, {(N-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(N-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_state = U_MUL;
                end
            end
            U_MUL: n_state = U_NUM;
            U_NUM: n_state = U_DIV;
            U_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = U_FIX;
                end
            end
            U_FIX: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    r_a    <= mag_dv;
                    r_b    <= mag_dn;
                    r_c    <= mag_den;
                    r_neg  <= i_dv[N] ^ i_dn[N] ^ i_den[N];
                    r_zero <= (mag_den == '0);
                    r_base <= i_base;
                end
            end
            U_MUL: begin
                r_num <= W'(r_a * r_b);
            end
            U_NUM: begin
                r_num <= {r_num[W-2:0], 1'b0} + W'(add_term);
                r_rem <= '0;
                r_cnt <= CW'(W);
            end
            U_DIV: begin
                r_rem <= ge ? (rem_sh - div_d) : rem_sh;
                r_num <= {r_num[W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            U_FIX: begin
                r_result <= r_zero ? r_base : clamped;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sim/tb_line_segment_clipper_top.sv
// Self-checking testbench for line_segment_clipper_top: clips segments against several
// windows and checks every result against a typed clip or one computed in SystemVerilog.
// Depends on lsc_pkg and the line_segment_clipper_top RTL.
`timescale 1ns / 1ps

module tb_line_segment_clipper_top;
    import lsc_pkg::*;

    localparam int COORD_BITS = 16;
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    // Cap on the quotient magnitude in the predictor; a quotient this large saturates the coordinate.
    localparam longint unsigned QUOTIENT_CAP = 64'd1 << 40;
    localparam int CLK_HALF = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Wait at the end; a four-slide clip at 16-bit coordinates fits within it.
    localparam int DRAIN_CYCLES = 200;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x_min;
        t_coord x_max;
        t_coord y_min;
        t_coord y_max;
    } t_window;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_segment;

    typedef struct packed {
        logic   visible;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_clip;

    // A directed row either carries its expected clip or leaves it to the predictor.
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        t_segment seg;
        logic     source;
        t_clip    clip;
    } t_directed_row;

    localparam t_clip REJECTED  = '0;
    localparam t_clip NOT_TYPED = '0;

    typedef enum logic [1:0] {
        STALL_NEVER,
        STALL_COIN,
        STALL_SPARSE,
        STALL_RUNS
    } t_stall_mode;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero; afterwards inputs change only at rising edges, through
    // nonblocking assignments.
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_coord i_start_x  = '0;
    t_coord i_start_y  = '0;
    t_coord i_end_x    = '0;
    t_coord i_end_y    = '0;

    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic   o_visible;
    t_coord o_clipped_start_x;
    t_coord o_clipped_start_y;
    t_coord o_clipped_end_x;
    t_coord o_clipped_end_y;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    always #CLK_HALF i_clk = ~i_clk;

    line_segment_clipper_top #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_visible        (o_visible),
        .o_clipped_start_x(o_clipped_start_x),
        .o_clipped_start_y(o_clipped_start_y),
        .o_clipped_end_x  (o_clipped_end_x),
        .o_clipped_end_y  (o_clipped_end_y),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------
    // Testbench state: the window the block should hold, the clips still owed
    // by the block in order of their input transfers, and the failure count.
    // ------------------------------------------------------------------
    t_window window;
    t_clip   pending_clips[$];
    int      mismatch_count = 0;
    int      burst_left     = 0;
    int      cycle_count    = 0;

    t_stall_mode stall_mode       = STALL_NEVER;
    int          mode_cycles_left = 0;
    int          run_cycles_left  = 0;

    // Directed segments, all against the window the block holds after reset
    // (x 0..1023, y 0..767). Trivial accepts and rejects are typed in; the
    // rows that slide endpoints go through the predictor. The last two rows
    // land exactly half way between two integers, with quotients of opposite sign.
    t_directed_row directed_rows [22] = '{
        '{'{0, 0, 1023, 767},                 TYPED,     '{1'b1, 0, 0, 1023, 767}},
        '{'{100, 200, 300, 400},              TYPED,     '{1'b1, 100, 200, 300, 400}},
        '{'{5, 5, 5, 5},                      TYPED,     '{1'b1, 5, 5, 5, 5}},
        '{'{-32768, -32768, -32768, 32767},   TYPED,     REJECTED},
        '{'{32767, 32767, 32767, -32768},     TYPED,     REJECTED},
        '{'{-32768, -32768, 32767, -32768},   TYPED,     REJECTED},
        '{'{-32768, 32767, 32767, 32767},     TYPED,     REJECTED},
        '{'{-1, -1, -1, -1},                  TYPED,     REJECTED},
        '{'{1024, 0, 1024, 767},              TYPED,     REJECTED},
        '{'{0, 768, 1023, 768},               TYPED,     REJECTED},
        '{'{-100, -100, 2000, 1000},          PREDICTED, NOT_TYPED},
        '{'{-32768, -32768, 32767, 32767},    PREDICTED, NOT_TYPED},
        '{'{512, -32768, 512, 32767},         PREDICTED, NOT_TYPED},
        '{'{-5, 300, 2000, 300},              PREDICTED, NOT_TYPED},
        '{'{-100, 700, 100, 900},             PREDICTED, NOT_TYPED},
        '{'{500, 400, 5000, -3000},           PREDICTED, NOT_TYPED},
        '{'{-3000, 100, 10, 10},              PREDICTED, NOT_TYPED},
        '{'{-50, 800, 1100, -40},             PREDICTED, NOT_TYPED},
        '{'{32767, -32768, -32768, 32767},    PREDICTED, NOT_TYPED},
        '{'{1025, 2, -3, 7},                  PREDICTED, NOT_TYPED},
        '{'{1024, 0, 1022, 1},                PREDICTED, NOT_TYPED},
        '{'{1024, 1, 1022, 0},                PREDICTED, NOT_TYPED}
    };

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------
    function automatic longint saturate_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // base + dv * dn / den, rounded to nearest with ties toward plus infinity.
    // The magnitude is rounded as floor((2*|dv*dn| + |den|) / (2*|den|)); on the
    // negative side one less is added, so that a tie moves toward zero instead.
    function automatic longint intercept_at(longint base, longint dv, longint dn,
                                            longint den);
        logic            negative;
        longint unsigned mag_v, mag_n, mag_d, numer, quot;
        negative = (dv < 0) ^ (dn < 0) ^ (den < 0);
        mag_v = (dv < 0) ? -dv : dv;
        mag_n = (dn < 0) ? -dn : dn;
        mag_d = (den < 0) ? -den : den;
        if (mag_d == 0) return saturate_coord(base);
        numer = 64'd2 * mag_v * mag_n + (negative ? mag_d - 64'd1 : mag_d);
        quot = numer / (64'd2 * mag_d);
        if (quot > QUOTIENT_CAP) quot = QUOTIENT_CAP;
        return saturate_coord(negative ? base - longint'(quot) : base + longint'(quot));
    endfunction

    // Left and below win over right and above, which matters for an inverted window.
    function automatic t_outcode region_code(longint x, longint y, t_window w);
        t_outcode code;
        code = CODE_NONE;
        if (x < w.x_min) code |= CODE_LEFT;
        else if (x > w.x_max) code |= CODE_RIGHT;
        if (y < w.y_min) code |= CODE_BELOW;
        else if (y > w.y_max) code |= CODE_ABOVE;
        return code;
    endfunction

    function automatic t_clip clip_segment(t_segment s, t_window w);
        longint   x1, y1, x2, y2, nx, ny;
        t_outcode c1, c2, code;
        logic     done, visible;
        t_clip    result;
        x1 = s.start_x;
        y1 = s.start_y;
        x2 = s.end_x;
        y2 = s.end_y;
        done = 1'b0;
        visible = 1'b0;
        for (int pass = 0; pass <= int'(MAX_SLIDES) && !done; pass++) begin
            c1 = region_code(x1, y1, w);
            c2 = region_code(x2, y2, w);
            if ((c1 | c2) == CODE_NONE) begin
                visible = 1'b1;
                done = 1'b1;
            end else if ((c1 & c2) != CODE_NONE || pass == int'(MAX_SLIDES)) begin
                done = 1'b1;
            end else begin
                // Slide the outside endpoint, the start point first, onto one edge.
                code = (c1 != CODE_NONE) ? c1 : c2;
                if ((code & CODE_ABOVE) != CODE_NONE) begin
                    ny = w.y_max;
                    nx = intercept_at(x1, x2 - x1, ny - y1, y2 - y1);
                end else if ((code & CODE_BELOW) != CODE_NONE) begin
                    ny = w.y_min;
                    nx = intercept_at(x1, x2 - x1, ny - y1, y2 - y1);
                end else if ((code & CODE_RIGHT) != CODE_NONE) begin
                    nx = w.x_max;
                    ny = intercept_at(y1, y2 - y1, nx - x1, x2 - x1);
                end else begin
                    nx = w.x_min;
                    ny = intercept_at(y1, y2 - y1, nx - x1, x2 - x1);
                end
                if (c1 != CODE_NONE) begin
                    x1 = nx;
                    y1 = ny;
                end else begin
                    x2 = nx;
                    y2 = ny;
                end
            end
        end
        result.visible = visible;
        result.start_x = visible ? t_coord'(x1) : '0;
        result.start_y = visible ? t_coord'(y1) : '0;
        result.end_x   = visible ? t_coord'(x2) : '0;
        result.end_y   = visible ? t_coord'(y2) : '0;
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly near the window span, so that slides are common, with some values
    // over the whole range, at the extremes, and just past an edge.
    function automatic t_coord random_coord(t_coord a, t_coord b);
        longint lo, hi, span, margin, v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        span = hi - lo + 1;
        margin = span / 2 + 4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                v = lo - margin + longint'($urandom_range(0, int'(span + 2 * margin - 1)));
            end
            6, 7: begin
                v = COORD_MIN + longint'($urandom_range(0, int'(COORD_MAX - COORD_MIN)));
            end
            8: begin
                case ($urandom_range(0, 5))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = 0;
                    3: v = -1;
                    4: v = lo;
                    default: v = hi;
                endcase
            end
            default: begin
                v = $urandom_range(0, 1) ? lo - 1 : hi + 1;
            end
        endcase
        return t_coord'(saturate_coord(v));
    endfunction

    function automatic t_window make_window(longint x_lo, longint x_hi, longint y_lo,
                                            longint y_hi);
        t_window w;
        w.x_min = t_coord'(x_lo);
        w.x_max = t_coord'(x_hi);
        w.y_min = t_coord'(y_lo);
        w.y_max = t_coord'(y_hi);
        return w;
    endfunction

    task automatic check_field(string name, longint expected, longint actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // One APB write: a setup cycle, then an access cycle that completes at the
    // edge where pready is seen high. psel stays high between back-to-back
    // writes; set_window lowers it after the last one.
    task automatic write_window_reg(t_reg_idx idx, t_coord value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_X_MIN: window.x_min = value;
            REG_X_MAX: window.x_max = value;
            REG_Y_MIN: window.y_min = value;
            default:   window.y_max = value;
        endcase
    endtask

    task automatic set_window(t_window w);
        write_window_reg(REG_X_MIN, w.x_min);
        write_window_reg(REG_X_MAX, w.x_max);
        write_window_reg(REG_Y_MIN, w.y_min);
        write_window_reg(REG_Y_MAX, w.y_max);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one segment and hold it until the input transfer. The sender runs
    // in bursts: when a burst is used up, valid drops for a random gap, mostly
    // short, sometimes longer.
    task automatic drive_segment(t_segment s, t_clip expected);
        int gap;
        i_in_valid <= 1'b1;
        i_start_x  <= s.start_x;
        i_start_y  <= s.start_y;
        i_end_x    <= s.end_x;
        i_end_y    <= s.end_y;
        do @(posedge i_clk); while (o_in_stall);
        pending_clips.push_back(expected);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random(int count);
        t_segment s;
        repeat (count) begin
            s.start_x = random_coord(window.x_min, window.x_max);
            s.start_y = random_coord(window.y_min, window.y_max);
            s.end_x   = random_coord(window.x_min, window.x_max);
            s.end_y   = random_coord(window.y_min, window.y_max);
            drive_segment(s, clip_segment(s, window));
        end
    endtask

    // The sender holds off until every clip owed has come back; with one result
    // per segment the block is then idle and its registers may be rewritten.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(t_window w, int count);
        wait_idle();
        set_window(w);
        send_random(count);
    endtask

    // ------------------------------------------------------------------
    // Result side. The stall pattern switches at random between modes: no
    // stall at all, a coin toss each cycle, rare stalls, and long runs of
    // stall and no stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (mode_cycles_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_cycles_left = $urandom_range(50, 500);
        end else begin
            mode_cycles_left--;
        end
        case (stall_mode)
            STALL_NEVER:  i_out_stall <= 1'b0;
            STALL_COIN:   i_out_stall <= 1'($urandom_range(0, 1));
            STALL_SPARSE: i_out_stall <= ($urandom_range(0, 7) == 0);
            default: begin
                if (run_cycles_left == 0) begin
                    i_out_stall <= !i_out_stall;
                    run_cycles_left = $urandom_range(1, 30);
                end else begin
                    run_cycles_left--;
                end
            end
        endcase
    end

    // Every result transfer is matched against the oldest clip still owed.
    always @(posedge i_clk) begin : result_check
        t_clip expected;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_clips.size() == 0) begin
                $error("result transfer with no segment outstanding");
                mismatch_count++;
            end else begin
                expected = pending_clips.pop_front();
                check_field("visible", expected.visible, o_visible);
                check_field("clipped_start_x", expected.start_x, o_clipped_start_x);
                check_field("clipped_start_y", expected.start_y, o_clipped_start_y);
                check_field("clipped_end_x", expected.end_x, o_clipped_end_x);
                check_field("clipped_end_y", expected.end_y, o_clipped_end_y);
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        t_window w;
        longint  x_lo, y_lo;
        window = make_window(0, 1023, 0, 767);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows and a first random batch against the reset window.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].source == TYPED) begin
                drive_segment(directed_rows[i].seg, directed_rows[i].clip);
            end else begin
                drive_segment(directed_rows[i].seg, clip_segment(directed_rows[i].seg, window));
            end
        end
        send_random(200);

        // Widest window: every segment is accepted untouched.
        run_phase(make_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX), 80);
        // A window of one point: x at its minimum and y at its maximum.
        run_phase(make_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX), 60);
        // Small window below the x axis.
        run_phase(make_window(10, 20, -20, -5), 120);
        // A window of one point.
        run_phase(make_window(5, 5, -3, -3), 80);
        // Inverted on both axes: extrapolated slides that saturate, and segments
        // that run out of slides.
        run_phase(make_window(500, -500, 300, -300), 150);

        // Random windows, some of them inverted on one or both axes.
        repeat (5) begin
            x_lo = COORD_MIN + longint'($urandom_range(0, int'(COORD_MAX - COORD_MIN)));
            y_lo = COORD_MIN + longint'($urandom_range(0, int'(COORD_MAX - COORD_MIN)));
            w = make_window(x_lo, saturate_coord(x_lo + $urandom_range(0, 3000)),
                            y_lo, saturate_coord(y_lo + $urandom_range(0, 3000)));
            if ($urandom_range(0, 3) == 0) {w.x_min, w.x_max} = {w.x_max, w.x_min};
            if ($urandom_range(0, 3) == 0) {w.y_min, w.y_max} = {w.y_max, w.y_min};
            run_phase(w, 50);
        end

        wait_idle();
        // Any stray result shows up as an unexpected transfer during this wait.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
